[sv/assert_macros.svh]
// Assertion macros shared by the macro-op emitter modules.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held low
`define AMOE_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held low
`define AMOE_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/amoe_pkg.sv]
// Shared types and constants of the AArch64 macro-op emitter.
// No dependencies.
package amoe_pkg;

    localparam int MAX_WORDS = 5;
    localparam int WCNT_W    = 3;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_MISALIGN  = 2'd1;
    localparam logic [1:0] STATUS_TOO_LONG  = 2'd2;
    localparam logic [1:0] STATUS_IMM_LARGE = 2'd3;

    typedef struct packed {
        logic [MAX_WORDS-1:0][31:0] words;
        logic [WCNT_W-1:0]          count;
        logic [1:0]                 status;
    } t_entry;

endpackage

[sv/arm64_macro_op_emitter_core.sv]
// Top level of the AArch64 macro-op emitter: front end, queue, back end.
// Depends on amoe_pkg, amoe_front, amoe_queue and amoe_back.
//
// Each accepted operation is expanded into one to five 32-bit AArch64 instruction
// words, or into one error result (zero word, tuser carrying the status), and kind 15
// produces nothing. The result port moves one word per cycle while m_axis_tready allows
// it. An operation has 1 word for most kinds, 2 for a byte clear,
// 1 or 2 for a mid-sized add or subtract, 3 for branches, byte ops and the NOP run,
// up to 4 for a constant and up to 5 for a large add or subtract. The front end
// expands a whole operation in the cycle it is accepted and takes a new one every
// cycle while the QUEUE_DEPTH-entry queue has room; the result register sets the
// sustained rate.
module arm64_macro_op_emitter_core #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // reg_req[4:0], src_reg[9:5], value[73:10], byte_imm[81:74], zero[87:82]
    input  logic [87:0] s_axis_tdata,
    // kind[3:0]
    input  logic [3:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // word[31:0]
    output logic [31:0] m_axis_tdata,
    output logic        m_axis_tlast,
    // status[1:0]
    output logic [1:0]  m_axis_tuser
);
    import amoe_pkg::*;

    t_entry w_entry;
    t_entry w_head;
    logic   w_push;
    logic   w_pop;
    logic   w_full;
    logic   w_empty;

    amoe_front u_front (
        .i_valid (s_axis_tvalid),
        .i_kind  (s_axis_tuser),
        .i_data  (s_axis_tdata),
        .i_full  (w_full),
        .o_ready (s_axis_tready),
        .o_push  (w_push),
        .o_entry (w_entry)
    );

    amoe_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_entry),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_empty (w_empty),
        .o_head  (w_head)
    );

    amoe_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_empty  (w_empty),
        .i_head   (w_head),
        .o_pop    (w_pop),
        .i_ready  (m_axis_tready),
        .o_valid  (m_axis_tvalid),
        .o_word   (m_axis_tdata),
        .o_last   (m_axis_tlast),
        .o_status (m_axis_tuser)
    );

endmodule

[sv/amoe_front.sv]
// Front end: unpacks one operation and expands it into its instruction words.
// Depends on amoe_pkg.
module amoe_front (
    input  logic             i_valid,
    input  logic [3:0]       i_kind,
    input  logic [87:0]      i_data,
    input  logic             i_full,
    output logic             o_ready,
    output logic             o_push,
    output amoe_pkg::t_entry o_entry
);
    import amoe_pkg::*;

    localparam logic [3:0] K_SET   = 4'd0;
    localparam logic [3:0] K_COPY  = 4'd1;
    localparam logic [3:0] K_SVC   = 4'd2;
    localparam logic [3:0] K_NOPS  = 4'd3;
    localparam logic [3:0] K_JZ    = 4'd4;
    localparam logic [3:0] K_JNZ   = 4'd5;
    localparam logic [3:0] K_INC   = 4'd6;
    localparam logic [3:0] K_DEC   = 4'd7;
    localparam logic [3:0] K_INCB  = 4'd8;
    localparam logic [3:0] K_DECB  = 4'd9;
    localparam logic [3:0] K_ADD   = 4'd10;
    localparam logic [3:0] K_SUB   = 4'd11;
    localparam logic [3:0] K_ADDB  = 4'd12;
    localparam logic [3:0] K_SUBB  = 4'd13;
    localparam logic [3:0] K_ZEROB = 4'd14;

    localparam logic [7:0] OP_ADD_IMM = 8'h91;
    localparam logic [7:0] OP_SUB_IMM = 8'hd1;
    localparam logic [7:0] OP_ADD_REG = 8'h8b;
    localparam logic [7:0] OP_SUB_REG = 8'hcb;
    localparam logic [7:0] MT_KEEP    = 8'hf2;
    localparam logic [7:0] MT_ZERO    = 8'hd2;
    localparam logic [7:0] MT_INVERT  = 8'h92;

    localparam logic [31:0] W_SVC   = 32'hd4000001;
    localparam logic [31:0] W_NOP   = 32'hd503201f;
    localparam logic [31:0] W_LDRB  = 32'h38400400;
    localparam logic [31:0] W_STRB  = 32'h38000400;
    localparam logic [31:0] W_TST   = 32'hf2401c1f;
    localparam logic [31:0] W_MOVR  = 32'haa0003e0;
    localparam logic [7:0]  OP_BCND = 8'h54;

    function automatic logic [31:0] mov_word(input logic [7:0] mt, input logic [15:0] imm,
                                             input logic [1:0] hw, input logic [4:0] rd);
        mov_word = {mt, 1'b1, hw, imm, rd};
    endfunction

    function automatic logic [31:0] arith_word(input logic [7:0] op, input logic [4:0] rd,
                                               input logic [11:0] imm, input logic sh);
        arith_word = {op, 1'b0, sh, imm, rd, rd};
    endfunction

    function automatic logic [31:0] ldrb_word(input logic [4:0] rt, input logic [4:0] rn);
        ldrb_word = W_LDRB | {22'd0, rn, rt};
    endfunction

    function automatic logic [31:0] strb_word(input logic [4:0] rt, input logic [4:0] rn);
        strb_word = W_STRB | {22'd0, rn, rt};
    endfunction

    logic [3:0]  w_kind;
    logic [4:0]  w_reg;
    logic [4:0]  w_src;
    logic [63:0] w_val;
    logic [7:0]  w_bimm;
    logic [4:0]  w_aux;
    logic [4:0]  w_set_rd;
    logic        w_neg;
    logic [15:0] w_dflt;
    logic [7:0]  w_lead;
    logic [3:0][31:0] w_sw;
    logic [2:0]  w_sn;
    logic        w_found;
    logic [15:0] w_part;
    logic [7:0]  w_op_imm;
    logic [7:0]  w_op_reg;
    logic        w_is_sub;
    logic [18:0] w_ofs;
    t_entry      w_e;

    assign w_kind = i_kind;
    assign w_reg  = i_data[4:0];
    assign w_src  = i_data[9:5];
    assign w_val  = i_data[73:10];
    assign w_bimm = i_data[81:74];
    assign w_aux  = (w_reg == 5'd17) ? 5'd16 : 5'd17;

    // Constant build: MOVZ or MOVN for the first non-default halfword, MOVK after
    always_comb begin
        w_set_rd = (w_kind == K_SET) ? w_reg : w_aux;
        w_neg    = w_val[63];
        w_dflt   = w_neg ? 16'hffff : 16'h0000;
        w_lead   = w_neg ? MT_INVERT : MT_ZERO;
        w_sw     = '0;
        w_sn     = '0;
        w_found  = 1'b0;
        w_part   = '0;
        for (int i = 0; i < 4; i++) begin
            w_part = w_val[16*i +: 16];
            if (w_part != w_dflt) begin
                if (!w_found) begin
                    w_sw[w_sn[1:0]] = mov_word(w_lead, w_neg ? ~w_part : w_part, 2'(i),
                                               w_set_rd);
                end else begin
                    w_sw[w_sn[1:0]] = mov_word(MT_KEEP, w_part, 2'(i), w_set_rd);
                end
                w_found = 1'b1;
                w_sn    = w_sn + 3'd1;
            end
        end
        if (!w_found) begin
            w_sw[0] = mov_word(w_lead, 16'h0000, 2'd0, w_set_rd);
            w_sn    = 3'd1;
        end
    end

    assign w_is_sub = (w_kind == K_SUB) || (w_kind == K_DEC) || (w_kind == K_DECB) ||
                      (w_kind == K_SUBB);
    assign w_op_imm = w_is_sub ? OP_SUB_IMM : OP_ADD_IMM;
    assign w_op_reg = w_is_sub ? OP_SUB_REG : OP_ADD_REG;
    assign w_ofs    = w_val[20:2] + 19'd1;

    always_comb begin
        w_e        = '0;
        w_e.status = STATUS_OK;
        unique case (w_kind)
            K_SET: begin
                w_e.words[3:0] = w_sw;
                w_e.count      = w_sn;
            end
            K_COPY: begin
                w_e.words[0] = W_MOVR | {11'd0, w_src, 11'd0, w_reg};
                w_e.count    = 3'd1;
            end
            K_SVC: begin
                w_e.words[0] = W_SVC;
                w_e.count    = 3'd1;
            end
            K_NOPS: begin
                w_e.words[0] = W_NOP;
                w_e.words[1] = W_NOP;
                w_e.words[2] = W_NOP;
                w_e.count    = 3'd3;
            end
            K_JZ, K_JNZ: begin
                if (w_val[1:0] != 2'b00) begin
                    w_e.status = STATUS_MISALIGN;
                    w_e.count  = 3'd1;
                end else if ((w_val[63:44] != 20'h00000) && (w_val[63:44] != 20'hfffff)) begin
                    w_e.status = STATUS_TOO_LONG;
                    w_e.count  = 3'd1;
                end else begin
                    w_e.words[0] = ldrb_word(w_aux, w_reg);
                    w_e.words[1] = W_TST | {22'd0, w_aux, 5'd0};
                    w_e.words[2] = {OP_BCND, w_ofs, 4'd0, (w_kind == K_JNZ)};
                    w_e.count    = 3'd3;
                end
            end
            K_INC, K_DEC: begin
                w_e.words[0] = arith_word(w_op_imm, w_reg, 12'd1, 1'b0);
                w_e.count    = 3'd1;
            end
            K_INCB, K_DECB, K_ADDB, K_SUBB: begin
                w_e.words[0] = ldrb_word(w_aux, w_reg);
                w_e.words[1] = arith_word(w_op_imm, w_aux,
                                          ((w_kind == K_ADDB) || (w_kind == K_SUBB)) ?
                                          {4'd0, w_bimm} : 12'd1, 1'b0);
                w_e.words[2] = strb_word(w_aux, w_reg);
                w_e.count    = 3'd3;
            end
            K_ADD, K_SUB: begin
                if (w_val[63:12] == '0) begin
                    w_e.words[0] = arith_word(w_op_imm, w_reg, w_val[11:0], 1'b0);
                    w_e.count    = 3'd1;
                end else if (w_val[63:24] == '0) begin
                    w_e.words[0] = arith_word(w_op_imm, w_reg, w_val[23:12], 1'b1);
                    w_e.words[1] = arith_word(w_op_imm, w_reg, w_val[11:0], 1'b0);
                    w_e.count    = (w_val[11:0] != '0) ? 3'd2 : 3'd1;
                end else if (w_val[63] || (w_val[62:0] == '1)) begin
                    w_e.status = STATUS_IMM_LARGE;
                    w_e.count  = 3'd1;
                end else begin
                    for (int k = 0; k < MAX_WORDS; k++) begin
                        if (3'(k) < w_sn) begin
                            w_e.words[k] = w_sw[k[1:0]];
                        end else if (3'(k) == w_sn) begin
                            w_e.words[k] = {w_op_reg, 3'd0, w_aux, 6'd0, w_reg, w_reg};
                        end
                    end
                    w_e.count = w_sn + 3'd1;
                end
            end
            K_ZEROB: begin
                w_e.words[0] = mov_word(MT_ZERO, 16'h0000, 2'd0, w_aux);
                w_e.words[1] = strb_word(w_aux, w_reg);
                w_e.count    = 3'd2;
            end
            default: begin
                w_e.count = 3'd0;
            end
        endcase
    end

    assign o_ready = !i_full;
    assign o_push  = i_valid && !i_full && (w_e.count != 3'd0);
    assign o_entry = w_e;

endmodule

[sv/amoe_queue.sv]
// Short queue of expanded operations between front and back end.
// Depends on amoe_pkg and assert_macros.svh.
`include "assert_macros.svh"
module amoe_queue #(
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  amoe_pkg::t_entry i_entry,
    input  logic             i_pop,
    output logic             o_full,
    output logic             o_empty,
    output amoe_pkg::t_entry o_head
);
    import amoe_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_entry             r_slot [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;
    logic [PTR_W-1:0]   n_wr_ptr;
    logic [PTR_W-1:0]   n_rd_ptr;
    logic [CNT_W-1:0]   n_count;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_slot[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        n_count = r_count + CNT_W'(i_push) - CNT_W'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_entry;
        end
    end

    `AMOE_ASSERT_IMP(a_no_overflow, i_clk, i_rst_n, i_push, !o_full, "push into full queue")
    `AMOE_ASSERT_IMP(a_no_underflow, i_clk, i_rst_n, i_pop, !o_empty, "pop from empty queue")

endmodule

[sv/amoe_back.sv]
// Back end: walks the queued words of each operation out through a result register.
// Depends on amoe_pkg and assert_macros.svh.
`include "assert_macros.svh"
module amoe_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_empty,
    input  amoe_pkg::t_entry i_head,
    output logic             o_pop,
    input  logic             i_ready,
    output logic             o_valid,
    output logic [31:0]      o_word,
    output logic             o_last,
    output logic [1:0]       o_status
);
    import amoe_pkg::*;

    logic              r_valid;
    logic [31:0]       r_word;
    logic              r_last;
    logic [1:0]        r_status;
    logic [WCNT_W-1:0] r_idx;
    logic [WCNT_W-1:0] n_idx;
    logic              w_take;
    logic              w_load;
    logic              w_is_last;

    assign w_take    = !r_valid || i_ready;
    assign w_load    = w_take && !i_empty;
    assign w_is_last = (r_idx == (i_head.count - 3'd1));
    assign o_pop     = w_load && w_is_last;
    assign n_idx     = w_is_last ? '0 : r_idx + 3'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else if (w_load) begin
            r_valid <= 1'b1;
            r_idx   <= n_idx;
        end else if (w_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_word   <= i_head.words[r_idx];
            r_last   <= w_is_last;
            r_status <= i_head.status;
        end
    end

    assign o_valid  = r_valid;
    assign o_word   = r_word;
    assign o_last   = r_last;
    assign o_status = r_status;

    `AMOE_ASSERT_IMP(a_idx_in_range, i_clk, i_rst_n, !i_empty, r_idx < i_head.count,
        "word index beyond entry")
    `AMOE_ASSERT_NXT(a_idx_rewind, i_clk, i_rst_n, o_pop, r_idx == '0,
        "index not rewound after last word")
    `AMOE_ASSERT_IMP(a_error_form, i_clk, i_rst_n, r_valid && (r_status != STATUS_OK),
        r_last && (r_word == '0), "error result not a lone zero word")

endmodule

[dv/tb_top.sv]
// Self-checking bench for arm64_macro_op_emitter_core: predicts instruction words per operation.
// Depends on amoe_pkg and the emitter RTL; scoreboard package and top module live in this file.
`timescale 1ns / 100ps

package insn_check_pkg;
    import amoe_pkg::*;

    typedef enum logic [3:0] {
        OP_SET, OP_COPY, OP_SYSCALL, OP_NOPS, OP_JZ, OP_JNZ, OP_INC, OP_DEC,
        OP_INCB, OP_DECB, OP_ADD, OP_SUB, OP_ADDB, OP_SUBB, OP_ZEROB, OP_UNUSED
    } t_op_kind;

    typedef struct {
        t_op_kind    kind;
        logic [4:0]  dst;
        logic [4:0]  src;
        logic [63:0] value;
        logic [7:0]  imm8;
    } t_op_item;

    typedef struct {
        logic [31:0] word;
        logic        last;
        logic [1:0]  status;
    } t_insn_res;

    localparam logic [7:0]  OP_ADD_IMM = 8'h91;
    localparam logic [7:0]  OP_SUB_IMM = 8'hd1;
    localparam logic [7:0]  OP_ADD_REG = 8'h8b;
    localparam logic [7:0]  OP_SUB_REG = 8'hcb;
    localparam logic [7:0]  MT_KEEP    = 8'hf2;
    localparam logic [7:0]  MT_ZERO    = 8'hd2;
    localparam logic [7:0]  MT_INVERT  = 8'h92;
    localparam logic [7:0]  BCOND_OP   = 8'h54;
    localparam logic [31:0] LDRB_BASE  = 32'h3840_0400;
    localparam logic [31:0] STRB_BASE  = 32'h3800_0400;
    localparam logic [31:0] TST_BYTE   = 32'hf240_1c1f;
    localparam logic [31:0] NOP_INSN   = 32'hd503_201f;
    localparam logic [31:0] SVC_INSN   = 32'hd400_0001;
    localparam logic [31:0] ORR_COPY   = 32'haa00_03e0;
    localparam int          MAX_REPORTS = 40;

    class insn_scoreboard;
        t_insn_res   expected_q[$];
        logic [31:0] words_q[$];
        int unsigned mismatches;

        function new();
            mismatches = 0;
        endfunction

        static function logic [4:0] scratch_for(logic [4:0] r);
            return (r == 5'd17) ? 5'd16 : 5'd17;
        endfunction

        static function logic [31:0] mov_insn(logic [7:0] mt, logic [15:0] imm16,
                                              logic [1:0] hw, logic [4:0] r);
            return {mt, 1'b1, hw, imm16, r};
        endfunction

        static function logic [31:0] arith_insn(logic [7:0] opc, logic [4:0] r,
                                                logic [11:0] imm12, logic sh);
            return {opc, 1'b0, sh, imm12, r, r};
        endfunction

        function void load_const(logic [4:0] r, logic [63:0] v);
            logic        neg;
            logic [15:0] dflt;
            logic [15:0] part;
            logic [7:0]  lead;
            int          first;
            neg   = v[63];
            dflt  = neg ? 16'hffff : 16'h0000;
            lead  = neg ? MT_INVERT : MT_ZERO;
            first = 4;
            for (int i = 3; i >= 0; i--) begin
                if (v[16*i +: 16] != dflt) first = i;
            end
            if (first == 4) begin
                words_q.push_back(mov_insn(lead, 16'h0, 2'd0, r));
                return;
            end
            part = v[16*first +: 16];
            words_q.push_back(mov_insn(lead, neg ? ~part : part, 2'(first), r));
            for (int i = first + 1; i < 4; i++) begin
                if (v[16*i +: 16] != dflt) words_q.push_back(mov_insn(MT_KEEP, v[16*i +: 16], 2'(i), r));
            end
        endfunction

        function logic [1:0] add_imm(logic [4:0] r, logic sub, logic [63:0] imm);
            logic [7:0] opc;
            logic [4:0] aux;
            opc = sub ? OP_SUB_IMM : OP_ADD_IMM;
            if (imm < 64'h1000) begin
                words_q.push_back(arith_insn(opc, r, imm[11:0], 1'b0));
            end else if (imm < 64'h100_0000) begin
                words_q.push_back(arith_insn(opc, r, imm[23:12], 1'b1));
                if (imm[11:0] != 12'h0) words_q.push_back(arith_insn(opc, r, imm[11:0], 1'b0));
            end else if (imm < 64'h7fff_ffff_ffff_ffff) begin
                aux = scratch_for(r);
                load_const(aux, imm);
                words_q.push_back({sub ? OP_SUB_REG : OP_ADD_REG, 3'b000, aux, 6'b0, r, r});
            end else begin
                return STATUS_IMM_LARGE;
            end
            return STATUS_OK;
        endfunction

        // jump range check kept as the block does it: on the top 20 bits of the offset
        function logic [1:0] cond_branch(logic [4:0] r, logic [63:0] off, logic cnd);
            logic [19:0] top;
            logic [31:0] field;
            logic [4:0]  aux;
            if (off[1:0] != 2'b00) return STATUS_MISALIGN;
            top = off[63:44];
            if (off[63] ? (top != 20'hfffff) : (top != 20'h0)) return STATUS_TOO_LONG;
            field = 32'd1 + {9'b0, off[24:2]};
            aux   = scratch_for(r);
            words_q.push_back(LDRB_BASE | {22'b0, r, aux});
            words_q.push_back(TST_BYTE | {22'b0, aux, 5'b0});
            words_q.push_back({BCOND_OP, field[18:0], 4'b0000, cnd});
            return STATUS_OK;
        endfunction

        function void note_op(t_op_item it);
            logic [1:0] st;
            logic [4:0] aux;
            st  = STATUS_OK;
            aux = scratch_for(it.dst);
            words_q.delete();
            case (it.kind)
                OP_SET:     load_const(it.dst, it.value);
                OP_COPY:    words_q.push_back(ORR_COPY | {11'b0, it.src, 11'b0, it.dst});
                OP_SYSCALL: words_q.push_back(SVC_INSN);
                OP_NOPS:    repeat (3) words_q.push_back(NOP_INSN);
                OP_JZ:      st = cond_branch(it.dst, it.value, 1'b0);
                OP_JNZ:     st = cond_branch(it.dst, it.value, 1'b1);
                OP_INC:     st = add_imm(it.dst, 1'b0, 64'd1);
                OP_DEC:     st = add_imm(it.dst, 1'b1, 64'd1);
                OP_INCB, OP_DECB: begin
                    words_q.push_back(LDRB_BASE | {22'b0, it.dst, aux});
                    st = add_imm(aux, it.kind == OP_DECB, 64'd1);
                    words_q.push_back(STRB_BASE | {22'b0, it.dst, aux});
                end
                OP_ADD:     st = add_imm(it.dst, 1'b0, it.value);
                OP_SUB:     st = add_imm(it.dst, 1'b1, it.value);
                OP_ADDB, OP_SUBB: begin
                    words_q.push_back(LDRB_BASE | {22'b0, it.dst, aux});
                    words_q.push_back(arith_insn(it.kind == OP_SUBB ? OP_SUB_IMM : OP_ADD_IMM,
                                                 aux, {4'b0, it.imm8}, 1'b0));
                    words_q.push_back(STRB_BASE | {22'b0, it.dst, aux});
                end
                OP_ZEROB: begin
                    load_const(aux, 64'd0);
                    words_q.push_back(STRB_BASE | {22'b0, it.dst, aux});
                end
                default: return;
            endcase
            if (st != STATUS_OK) begin
                expected_q.push_back('{32'h0, 1'b1, st});
            end else begin
                foreach (words_q[i]) expected_q.push_back('{words_q[i], i == words_q.size() - 1, STATUS_OK});
            end
        endfunction

        function void check_word(logic [31:0] word, logic last, logic [1:0] status);
            t_insn_res want;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: expected nothing, got word %h last %b status %0d",
                             $time, word, last, status);
                return;
            end
            want = expected_q.pop_front();
            if (word !== want.word || last !== want.last || status !== want.status) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: expected word %h last %b status %0d, got word %h last %b status %0d",
                             $time, want.word, want.last, want.status, word, last, status);
            end
        endfunction
    endclass
endpackage

module tb_top;
    import amoe_pkg::*;
    import insn_check_pkg::*;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    // reg_req[4:0], src_reg[9:5], value[73:10], byte_imm[81:74], zero[87:82]
    logic [87:0] s_axis_tdata = '0;
    // kind[3:0]
    logic [3:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // word[31:0]
    logic [31:0] m_axis_tdata;
    logic        m_axis_tlast;
    // status[1:0]
    logic [1:0]  m_axis_tuser;

    int unsigned    idle_pct = 25;
    insn_scoreboard board;

    arm64_macro_op_emitter_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= idle_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                board.note_op('{t_op_kind'(s_axis_tuser), s_axis_tdata[4:0],
                                s_axis_tdata[9:5], s_axis_tdata[73:10], s_axis_tdata[81:74]});
            end
            if (m_axis_tvalid && m_axis_tready) begin
                board.check_word(m_axis_tdata, m_axis_tlast, m_axis_tuser);
            end
        end
    end

    function automatic t_op_item mk(t_op_kind k, logic [4:0] d, logic [4:0] s,
                                    logic [63:0] v, logic [7:0] b);
        t_op_item it;
        it = '{k, d, s, v, b};
        return it;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [63:0] rand_halfwords();
        logic [63:0] v;
        for (int i = 0; i < 4; i++) begin
            case ($urandom_range(2))
                0:       v[16*i +: 16] = 16'h0000;
                1:       v[16*i +: 16] = 16'hffff;
                default: v[16*i +: 16] = 16'($urandom);
            endcase
        end
        return v;
    endfunction

    function automatic logic [63:0] set_value();
        logic [63:0] v;
        case ($urandom_range(9))
            0: begin
                v = rand64();
                v[63:16] = {48{v[15]}};
            end
            1, 2, 3, 4, 5, 6: v = rand_halfwords();
            default:          v = rand64();
        endcase
        return v;
    endfunction

    function automatic logic [63:0] arith_value();
        logic [63:0] v;
        case ($urandom_range(9))
            0, 1, 2: v = 64'($urandom_range(4095));
            3, 4, 5: begin
                v = 64'($urandom_range(24'hff_ffff, 4096));
                if ($urandom_range(1) == 0) v[11:0] = 12'h0;
                if (v < 64'h1000) v[12] = 1'b1;
            end
            6, 7: begin
                v = rand_halfwords();
                v[63] = 1'b0;
                v[$urandom_range(62, 24)] = 1'b1;
            end
            8: begin
                v = rand64();
                v[63] = 1'b1;
            end
            default: begin
                case ($urandom_range(5))
                    0:       v = 64'h7fff_ffff_ffff_ffff;
                    1:       v = 64'h7fff_ffff_ffff_fffe;
                    2:       v = 64'h0000_0000_0000_0fff;
                    3:       v = 64'h0000_0000_0000_1000;
                    4:       v = 64'h0000_0000_00ff_ffff;
                    default: v = 64'h0000_0000_0100_0000;
                endcase
            end
        endcase
        return v;
    endfunction

    function automatic logic [63:0] jump_offset();
        logic [63:0] v;
        logic        sgn;
        v = rand64();
        case ($urandom_range(9))
            0: v[1:0] = 2'($urandom_range(3, 1));
            1: begin
                v[62] = ~v[63];
                v[1:0] = 2'b00;
            end
            2: begin
                case ($urandom_range(3))
                    0:       v = 64'h0000_0fff_ffff_fffc;
                    1:       v = 64'hffff_f000_0000_0000;
                    2:       v = 64'h0000_1000_0000_0000;
                    default: v = 64'hffff_efff_ffff_fffc;
                endcase
            end
            default: begin
                sgn = v[63];
                if ($urandom_range(1) == 0) v[63:21] = {43{sgn}};
                else v[63:44] = {20{sgn}};
                v[1:0] = 2'b00;
            end
        endcase
        return v;
    endfunction

    function automatic t_op_item rand_op();
        t_op_item    it;
        int unsigned pick;
        it.dst   = 5'($urandom_range(31));
        it.src   = 5'($urandom_range(31));
        it.imm8  = 8'($urandom_range(255));
        it.value = rand64();
        pick = $urandom_range(99);
        if (pick < 2) begin
            it.kind = OP_UNUSED;
        end else if (pick < 16) begin
            it.kind  = OP_SET;
            it.value = set_value();
        end else if (pick < 32) begin
            it.kind  = pick[0] ? OP_SUB : OP_ADD;
            it.value = arith_value();
        end else if (pick < 48) begin
            it.kind  = pick[0] ? OP_JNZ : OP_JZ;
            it.value = jump_offset();
        end else begin
            it.kind = t_op_kind'($urandom_range(14));
        end
        return it;
    endfunction

    task automatic send_op(input t_op_item it);
        while ($urandom_range(99) < idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tdata  <= {6'b000000, it.imm8, it.value, it.src, it.dst};
        s_axis_tuser  <= it.kind;
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    initial begin
        board = new();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_op(mk(OP_SET,     5'd0,  5'd0,  64'h0,                   8'h00));
        send_op(mk(OP_SET,     5'd31, 5'd31, 64'hffff_ffff_ffff_ffff, 8'hff));
        send_op(mk(OP_SET,     5'd3,  5'd9,  64'h1234_0000_ffff_5678, 8'h00));
        send_op(mk(OP_SET,     5'd17, 5'd0,  64'h8000_0000_0000_0000, 8'h00));
        send_op(mk(OP_SET,     5'd4,  5'd0,  64'hffff_ffff_ffff_0000, 8'h00));
        send_op(mk(OP_COPY,    5'd5,  5'd31, 64'h0,                   8'h00));
        send_op(mk(OP_SYSCALL, 5'd0,  5'd0,  64'h0,                   8'h00));
        send_op(mk(OP_NOPS,    5'd0,  5'd0,  64'h0,                   8'h00));
        send_op(mk(OP_JZ,      5'd17, 5'd0,  64'h0000_0fff_ffff_fffc, 8'h00));
        send_op(mk(OP_JNZ,     5'd2,  5'd0,  64'hffff_f000_0000_0000, 8'h00));
        send_op(mk(OP_JZ,      5'd1,  5'd0,  64'h2,                   8'h00));
        send_op(mk(OP_JNZ,     5'd1,  5'd0,  64'h0000_1000_0000_0000, 8'h00));
        send_op(mk(OP_JZ,      5'd1,  5'd0,  64'hffff_efff_ffff_fffc, 8'h00));
        send_op(mk(OP_JNZ,     5'd1,  5'd0,  64'h0000_1000_0000_0001, 8'h00));
        send_op(mk(OP_INC,     5'd0,  5'd0,  64'h0,                   8'h00));
        send_op(mk(OP_DEC,     5'd31, 5'd0,  64'h0,                   8'h00));
        send_op(mk(OP_INCB,    5'd17, 5'd0,  64'h0,                   8'h00));
        send_op(mk(OP_DECB,    5'd3,  5'd0,  64'h0,                   8'h00));
        send_op(mk(OP_ADD,     5'd6,  5'd0,  64'h0fff,                8'h00));
        send_op(mk(OP_SUB,     5'd7,  5'd0,  64'h1000,                8'h00));
        send_op(mk(OP_ADD,     5'd8,  5'd0,  64'h12_3456,             8'h00));
        send_op(mk(OP_ADD,     5'd17, 5'd0,  64'h7fff_ffff_ffff_fffe, 8'h00));
        send_op(mk(OP_SUB,     5'd9,  5'd0,  64'h7fff_ffff_ffff_ffff, 8'h00));
        send_op(mk(OP_ADD,     5'd9,  5'd0,  64'hffff_ffff_ffff_ffff, 8'h00));
        send_op(mk(OP_ADDB,    5'd10, 5'd0,  64'h0,                   8'hff));
        send_op(mk(OP_SUBB,    5'd17, 5'd0,  64'h0,                   8'h00));
        send_op(mk(OP_ZEROB,   5'd17, 5'd0,  64'h0,                   8'h00));
        send_op(mk(OP_UNUSED,  5'd0,  5'd0,  64'h0,                   8'h00));

        for (int n = 0; n < 430; n++) begin
            if (n == 150) idle_pct <= 0;
            if (n == 270) idle_pct <= 25;
            send_op(rand_op());
        end
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);

        while (board.expected_q.size() != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);
        if (board.mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin
        #200_000;
        $display("Mismatches found");
        $finish;
    end
endmodule
